/* sv/rgb_led_pulse_symbol_encoder_macros.svh */
// assertion macros for the pulse symbol encoder port checker
`ifndef RGB_LED_PULSE_SYMBOL_ENCODER_MACROS_SVH
`define RGB_LED_PULSE_SYMBOL_ENCODER_MACROS_SVH

// clocked assertion, quiet while reset is held
`define RLPSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define RLPSE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/rlpse_pkg.sv */
// types and constants of the rgb led pulse symbol encoder
`timescale 1ns / 1ps

package rlpse_pkg;

    // colour word and symbol counts
    localparam int CHAN_W      = 8;
    localparam int WORD_W      = 3 * CHAN_W;
    localparam int DATA_BITS   = WORD_W;
    localparam int IDX_W       = 5;
    localparam int TICKS_W     = 15;
    localparam int SHORT_W     = 8;
    localparam int PROD_W      = 2 * CHAN_W;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS       = 3'd0,
        REG_SHORT_TICKS      = 3'd1,
        REG_LONG_TICKS       = 3'd2,
        REG_RESET_HALF_TICKS = 3'd3
    } t_cfg_reg;

    // register reset values
    localparam logic [CHAN_W-1:0]  BRIGHTNESS_RST       = 8'd64;
    localparam logic [SHORT_W-1:0] SHORT_TICKS_RST      = 8'd3;
    localparam logic [SHORT_W-1:0] LONG_TICKS_RST       = 8'd9;
    localparam logic [TICKS_W-1:0] RESET_HALF_TICKS_RST = 15'd250;

    // input opcodes
    localparam logic OP_RGB888 = 1'b0;
    localparam logic OP_RGB565 = 1'b1;

    // pulse timing handed to the back end
    typedef struct packed {
        logic [SHORT_W-1:0] short_ticks;
        logic [SHORT_W-1:0] long_ticks;
        logic [TICKS_W-1:0] reset_half_ticks;
    } t_timing;

endpackage

/* sv/rlpse_fifo.sv */
// small word queue between the colour front end and the symbol back end
`timescale 1ns / 1ps

module rlpse_fifo import rlpse_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = WORD_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* sv/rlpse_front.sv */
// front end: takes colour words, decodes the format and scales by brightness
`timescale 1ns / 1ps

module rlpse_front import rlpse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CHAN_W-1:0] i_brightness,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [15:0]       i_rgb565,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output logic [WORD_W-1:0] o_push_word
);

    // exact p / 255 for any product of two bytes
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {1'b0, p} + {9'd0, p[PROD_W-1:CHAN_W]} + 17'd1;
        return t[PROD_W-1:CHAN_W];
    endfunction

    logic              r_s1_valid;
    logic [CHAN_W-1:0] r_s1_r, r_s1_g, r_s1_b;
    logic              r_s2_valid;
    logic [PROD_W-1:0] r_s2_r, r_s2_g, r_s2_b;
    logic [CHAN_W-1:0] dec_r, dec_g, dec_b;
    logic              s1_adv, s2_adv, accept, black;

    // stage handshake
    assign s2_adv     = i_push_ready;
    assign s1_adv     = !r_s2_valid || s2_adv;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // colour format decode, rgb565 zero or with the top bit set is black
    assign black = (i_rgb565 == '0) || i_rgb565[15];
    always_comb begin
        dec_r = i_red;
        dec_g = i_green;
        dec_b = i_blue;
        if (i_opcode == OP_RGB565) begin
            if (black) begin
                dec_r = '0;
                dec_g = '0;
                dec_b = '0;
            end else begin
                dec_r = {i_rgb565[15:11], 3'b000};
                dec_g = {i_rgb565[10:5], 2'b00};
                dec_b = {i_rgb565[4:0], 3'b000};
            end
        end
    end

    // stage one: decoded channels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_r <= dec_r;
            r_s1_g <= dec_g;
            r_s1_b <= dec_b;
        end
    end

    // stage two: brightness products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_s2_r <= PROD_W'(r_s1_r) * PROD_W'(i_brightness);
            r_s2_g <= PROD_W'(r_s1_g) * PROD_W'(i_brightness);
            r_s2_b <= PROD_W'(r_s1_b) * PROD_W'(i_brightness);
        end
    end

    // scaled word in green, red, blue order
    assign o_push_valid = r_s2_valid;
    assign o_push_word  = {div255(r_s2_g), div255(r_s2_r), div255(r_s2_b)};

endmodule

/* sv/rlpse_back.sv */
// back end: turns each queued colour word into 25 pulse symbols
`timescale 1ns / 1ps

module rlpse_back import rlpse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_timing            i_timing,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  logic [WORD_W-1:0]  i_q_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_first_level,
    output logic [TICKS_W-1:0] o_first_ticks,
    output logic               o_second_level,
    output logic [TICKS_W-1:0] o_second_ticks,
    output logic               o_last_symbol
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS);

    logic               r_active;
    logic [WORD_W-1:0]  r_word;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid;
    logic               r_first_level;
    logic [TICKS_W-1:0] r_first_ticks;
    logic [TICKS_W-1:0] r_second_ticks;
    logic               r_last_symbol;
    logic               load, at_last, emit;
    logic [TICKS_W-1:0] short_t, long_t;

    assign load    = !r_out_valid || i_out_ready;
    assign at_last = (r_idx == LAST_IDX);
    assign emit    = load && r_active;
    assign o_q_pop = i_q_valid && (!r_active || (emit && at_last));
    assign short_t = TICKS_W'(i_timing.short_ticks);
    assign long_t  = TICKS_W'(i_timing.long_ticks);

    // symbol sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else if (o_q_pop) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else if (emit) begin
            if (at_last) begin
                r_active <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // word shifts out msb first
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_word <= i_q_word;
        end else if (emit) begin
            r_word <= {r_word[WORD_W-2:0], 1'b0};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (at_last) begin
                r_first_level  <= 1'b0;
                r_first_ticks  <= i_timing.reset_half_ticks;
                r_second_ticks <= i_timing.reset_half_ticks;
                r_last_symbol  <= 1'b1;
            end else begin
                r_first_level  <= 1'b1;
                r_first_ticks  <= r_word[WORD_W-1] ? long_t : short_t;
                r_second_ticks <= r_word[WORD_W-1] ? short_t : long_t;
                r_last_symbol  <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_first_level  = r_first_level;
    assign o_first_ticks  = r_first_ticks;
    assign o_second_level = 1'b0;
    assign o_second_ticks = r_second_ticks;
    assign o_last_symbol  = r_last_symbol;

endmodule

/* sv/rgb_led_pulse_symbol_encoder.sv */
// Top level of the rgb led pulse symbol encoder.
// Path: an accepted colour word passes the two front-end stages, the queue and the back-end
// sequencer to the output register. Throughput: 25 symbols per word at one a cycle while the
// output is not stalled, set by the back-end symbol sequencer; the front end and queue run ahead.
// Reset: synchronous active low; clears control state and loads the register defaults.
`timescale 1ns / 1ps

module rgb_led_pulse_symbol_encoder import rlpse_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // colour words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic [15:0]           i_rgb565,
    // pulse symbols
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_first_level,
    output logic [TICKS_W-1:0]    o_first_ticks,
    output logic                  o_second_level,
    output logic [TICKS_W-1:0]    o_second_ticks,
    output logic                  o_last_symbol
);

    logic [CHAN_W-1:0] r_brightness;
    t_timing           r_timing;
    logic              push_valid, push_ready;
    logic [WORD_W-1:0] push_word;
    logic              pop_valid, pop;
    logic [WORD_W-1:0] pop_word;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness              <= BRIGHTNESS_RST;
            r_timing.short_ticks      <= SHORT_TICKS_RST;
            r_timing.long_ticks       <= LONG_TICKS_RST;
            r_timing.reset_half_ticks <= RESET_HALF_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BRIGHTNESS: begin
                    r_brightness <= i_cfg_data[CHAN_W-1:0];
                end
                REG_SHORT_TICKS: begin
                    r_timing.short_ticks <= i_cfg_data[SHORT_W-1:0];
                end
                REG_LONG_TICKS: begin
                    r_timing.long_ticks <= i_cfg_data[SHORT_W-1:0];
                end
                REG_RESET_HALF_TICKS: begin
                    r_timing.reset_half_ticks <= i_cfg_data[TICKS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // colour decode and scaling
    rlpse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_brightness (r_brightness),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_rgb565     (i_rgb565),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_word  (push_word)
    );

    // word queue
    rlpse_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WORD_W)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_word),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_data   (pop_word)
    );

    // symbol generation
    rlpse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_timing       (r_timing),
        .i_q_valid      (pop_valid),
        .o_q_pop        (pop),
        .i_q_word       (pop_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_first_level  (o_first_level),
        .o_first_ticks  (o_first_ticks),
        .o_second_level (o_second_level),
        .o_second_ticks (o_second_ticks),
        .o_last_symbol  (o_last_symbol)
    );

endmodule

/* sv/rlpse_checker.sv */
// port-level checker for the pulse symbol encoder, bound to the top level
`timescale 1ns / 1ps
`include "rgb_led_pulse_symbol_encoder_macros.svh"

module rlpse_checker import rlpse_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_first_level,
    input logic [TICKS_W-1:0]    o_first_ticks,
    input logic                  o_second_level,
    input logic [TICKS_W-1:0]    o_second_ticks,
    input logic                  o_last_symbol
);

    logic out_last;

    assign out_last = o_out_valid && o_last_symbol;

    // nothing shown on the output just after reset
    `RLPSE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "symbol shown after reset")

    // a shown symbol waits until it is taken
    `RLPSE_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "symbol dropped while stalled")

    // the line always returns low in the second part
    `RLPSE_ASSERT(a_second_low, o_out_valid |-> !o_second_level, "second part not low")

    // data symbols start high, the frame end symbol starts low
    `RLPSE_ASSERT(a_first_level, o_out_valid |-> (o_first_level != o_last_symbol), "bad first level")

    // the frame end symbol has equal halves
    `RLPSE_ASSERT(a_reset_even, out_last |-> (o_first_ticks == o_second_ticks), "uneven reset")

endmodule

bind rgb_led_pulse_symbol_encoder rlpse_checker u_rlpse_checker (.*);

/* tb/sv/rlpse_symbol_checker.sv */
// symbol checker: predicts the pulse symbols of each colour word and compares them
`timescale 1ns / 1ps

module rlpse_symbol_checker import rlpse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_opcode,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic [15:0]           i_rgb565,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_first_level,
    input  logic [TICKS_W-1:0]    i_first_ticks,
    input  logic                  i_second_level,
    input  logic [TICKS_W-1:0]    i_second_ticks,
    input  logic                  i_last_symbol,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic               first_level;
        logic [TICKS_W-1:0] first_ticks;
        logic               second_level;
        logic [TICKS_W-1:0] second_ticks;
        logic               last_symbol;
    } t_symbol;

    // local copy of the register file
    logic [CHAN_W-1:0]  brightness;
    logic [SHORT_W-1:0] short_ticks;
    logic [SHORT_W-1:0] long_ticks;
    logic [TICKS_W-1:0] half_ticks;

    t_symbol pending_symbols[$];
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    // channel times brightness over 255, truncated
    function automatic logic [CHAN_W-1:0] dim_channel(input logic [CHAN_W-1:0] level);
        return CHAN_W'((int'(level) * int'(brightness)) / 255);
    endfunction

    // scaled colour word in green, red, blue order
    function automatic logic [WORD_W-1:0] grb_word(
        input logic        op,
        input logic [7:0]  red,
        input logic [7:0]  green,
        input logic [7:0]  blue,
        input logic [15:0] packed565
    );
        logic [CHAN_W-1:0] r, g, b;
        if (op == OP_RGB888) begin
            r = red;
            g = green;
            b = blue;
        end else if (packed565 == 16'h0000 || packed565[15]) begin
            // zero word or top bit set reads as black
            r = '0;
            g = '0;
            b = '0;
        end else begin
            r = {packed565[15:11], 3'b000};
            g = {packed565[10:5], 2'b00};
            b = {packed565[4:0], 3'b000};
        end
        return {dim_channel(g), dim_channel(r), dim_channel(b)};
    endfunction

    // 24 data symbols msb first, then the trailing reset symbol
    task automatic queue_symbols(input logic [WORD_W-1:0] colour);
        t_symbol s;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            s.first_level  = 1'b1;
            s.second_level = 1'b0;
            s.last_symbol  = 1'b0;
            s.first_ticks  = TICKS_W'(colour[i] ? long_ticks : short_ticks);
            s.second_ticks = TICKS_W'(colour[i] ? short_ticks : long_ticks);
            pending_symbols.push_back(s);
        end
        s.first_level  = 1'b0;
        s.first_ticks  = half_ticks;
        s.second_level = 1'b0;
        s.second_ticks = half_ticks;
        s.last_symbol  = 1'b1;
        pending_symbols.push_back(s);
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // watch all three channels
    always @(posedge i_clk) begin : watch_channels
        t_symbol seen;
        t_symbol want;
        if (!i_rst_n) begin
            brightness  = BRIGHTNESS_RST;
            short_ticks = SHORT_TICKS_RST;
            long_ticks  = LONG_TICKS_RST;
            half_ticks  = RESET_HALF_TICKS_RST;
            pending_symbols.delete();
            o_pending <= 0;
        end else begin
            // outgoing symbol against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                seen.first_level  = i_first_level;
                seen.first_ticks  = i_first_ticks;
                seen.second_level = i_second_level;
                seen.second_ticks = i_second_ticks;
                seen.last_symbol  = i_last_symbol;
                if (pending_symbols.size() == 0) begin
                    note_failure($sformatf("symbol with none expected: %0d/%0d %0d/%0d last %0d",
                        seen.first_level, seen.first_ticks, seen.second_level,
                        seen.second_ticks, seen.last_symbol));
                end else begin
                    want = pending_symbols.pop_front();
                    if (seen.first_level !== want.first_level
                            || seen.first_ticks !== want.first_ticks
                            || seen.second_level !== want.second_level
                            || seen.second_ticks !== want.second_ticks
                            || seen.last_symbol !== want.last_symbol) begin
                        note_failure($sformatf(
                            "symbol mismatch: expected %0d/%0d %0d/%0d last %0d, got %0d/%0d %0d/%0d last %0d",
                            want.first_level, want.first_ticks, want.second_level,
                            want.second_ticks, want.last_symbol,
                            seen.first_level, seen.first_ticks, seen.second_level,
                            seen.second_ticks, seen.last_symbol));
                    end
                end
            end
            // register writes, out of range indexes ignored
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_BRIGHTNESS:       brightness  = i_cfg_data[CHAN_W-1:0];
                    REG_SHORT_TICKS:      short_ticks = i_cfg_data[SHORT_W-1:0];
                    REG_LONG_TICKS:       long_ticks  = i_cfg_data[SHORT_W-1:0];
                    REG_RESET_HALF_TICKS: half_ticks  = i_cfg_data[TICKS_W-1:0];
                    default: ;
                endcase
            end
            // accepted colour word
            if (i_in_valid && i_in_ready) begin
                queue_symbols(grb_word(i_opcode, i_red, i_green, i_blue, i_rgb565));
            end
            o_pending <= pending_symbols.size();
        end
    end

endmodule

/* tb/sv/tb_rgb_led_pulse_symbol_encoder.sv */
// testbench top: drives colour words and register writes into the pulse symbol encoder
`timescale 1ns / 1ps

module tb_rgb_led_pulse_symbol_encoder;
    import rlpse_pkg::*;

    localparam int STALL_MAX       = 13;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_PHASES   = 9;
    localparam int WORDS_PER_PHASE = 50;
    localparam int DRAIN_CYCLES    = 20;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_opcode;
    logic [7:0]            i_red;
    logic [7:0]            i_green;
    logic [7:0]            i_blue;
    logic [15:0]           i_rgb565;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_first_level;
    logic [TICKS_W-1:0]    o_first_ticks;
    logic                  o_second_level;
    logic [TICKS_W-1:0]    o_second_ticks;
    logic                  o_last_symbol;

    int fail_count;
    int pending;
    bit sender_fast   = 1'b0;
    bit receiver_fast = 1'b0;

    rgb_led_pulse_symbol_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_rgb565       (i_rgb565),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_first_level  (o_first_level),
        .o_first_ticks  (o_first_ticks),
        .o_second_level (o_second_level),
        .o_second_ticks (o_second_ticks),
        .o_last_symbol  (o_last_symbol)
    );

    rlpse_symbol_checker u_symbol_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_rgb565       (i_rgb565),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_first_level  (o_first_level),
        .i_first_ticks  (o_first_ticks),
        .i_second_level (o_second_level),
        .i_second_ticks (o_second_ticks),
        .i_last_symbol  (o_last_symbol),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one colour word, after a random gap unless in a fast stretch
    task automatic send_colour(
        input logic        op,
        input logic [7:0]  red,
        input logic [7:0]  green,
        input logic [7:0]  blue,
        input logic [15:0] packed565
    );
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_red      <= red;
        i_green    <= green;
        i_blue     <= blue;
        i_rgb565   <= packed565;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_random();
        logic [15:0] packed565;
        packed565 = 16'($urandom);
        if ($urandom_range(0, 15) == 0) begin
            packed565 = 16'h0000;
        end
        send_colour(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), packed565);
    endtask

    // fixed colours: channel extremes, both formats, the black rgb565 words
    task automatic send_directed();
        send_colour(OP_RGB888, 8'h00, 8'h00, 8'h00, 16'hFFFF);
        send_colour(OP_RGB888, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
        send_colour(OP_RGB888, 8'h80, 8'h01, 8'hAA, 16'h5555);
        // zero word is black
        send_colour(OP_RGB565, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
        // top bit set is black whatever the rest holds
        send_colour(OP_RGB565, 8'h12, 8'h34, 8'h56, 16'h8000);
        send_colour(OP_RGB565, 8'hFF, 8'h00, 8'hFF, 16'hFFFF);
        send_colour(OP_RGB565, 8'h00, 8'h00, 8'h00, 16'h7FFF);
        // lowest bit of each packed channel
        send_colour(OP_RGB565, 8'hA5, 8'h5A, 8'hC3, 16'h0821);
    endtask

    // one register write, valid left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // all registers, junk in the unused upper data bits
    task automatic set_registers(
        input logic [7:0]  bright,
        input logic [7:0]  short_len,
        input logic [7:0]  long_len,
        input logic [14:0] half_len
    );
        write_reg(REG_BRIGHTNESS, {8'($urandom), bright});
        write_reg(REG_SHORT_TICKS, {8'($urandom), short_len});
        write_reg(REG_LONG_TICKS, {8'($urandom), long_len});
        write_reg(REG_RESET_HALF_TICKS, {1'($urandom), half_len});
        // an index past the last register must change nothing
        write_reg(3'(REG_RESET_HALF_TICKS) + 3'($urandom_range(1, 4)), 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering and wait for every predicted symbol to arrive
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_half();
        case ($urandom_range(0, 5))
            0:       return 15'd0;
            1:       return 15'd1;
            2:       return 15'h7FFF;
            3:       return 15'($urandom_range(1, 600));
            default: return 15'($urandom);
        endcase
    endfunction

    // symbol sink with random stalls and two long hold-offs
    initial begin : symbol_sink
        int n_taken;
        int stall;
        n_taken = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                n_taken++;
                if (n_taken % 100 == 0) begin
                    receiver_fast = ($urandom_range(0, 2) == 0);
                end
                if (n_taken == 2500 || n_taken == 8000) begin
                    stall = HOLD_CYCLES;
                end else begin
                    stall = receiver_fast ? 0 : $urandom_range(0, STALL_MAX);
                end
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
                    || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL rgb_led_pulse_symbol_encoder");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_RGB888;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_rgb565    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults, then extreme settings
        send_directed();
        wait_idle();
        set_registers(8'd255, 8'd255, 8'd1, 15'h7FFF);
        send_directed();
        wait_idle();
        // zero tick durations pass straight through
        set_registers(8'd1, 8'd0, 8'd0, 15'd0);
        repeat (3) send_random();

        // random phases, each under fresh register settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            set_registers(pick_byte(), pick_byte(), pick_byte(), pick_half());
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 20 == 0) begin
                    sender_fast = ($urandom_range(0, 2) == 0);
                end
                send_random();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS rgb_led_pulse_symbol_encoder");
        end else begin
            $display("FAIL rgb_led_pulse_symbol_encoder");
        end
        $finish;
    end

endmodule
